/* design/idesc_pkg.sv */
// shared types, widths and constants of the input debounce and edge scan block
`timescale 1ns / 1ps

package idesc_pkg;

   // field widths of one scan transaction
   localparam int INPUT_WIDTH  = 12;
   localparam int OUTPUT_WIDTH = 8;
   localparam int RELAY_WIDTH  = 32;
   localparam int TICKS_WIDTH  = 5;

   // defaults for the count parameters of the top level
   localparam int INPUT_COUNT_DEFAULT  = 12;
   localparam int OUTPUT_COUNT_DEFAULT = 8;
   localparam int RELAY_COUNT_DEFAULT  = 32;

   // debounce delay after reset
   localparam logic [TICKS_WIDTH-1:0] TICKS_RESET = 5'd10;

   typedef struct packed {
      logic [INPUT_WIDTH-1:0]  raw_pins;
      logic                    tick;
      logic [OUTPUT_WIDTH-1:0] output_image;
      logic [RELAY_WIDTH-1:0]  relay_image;
   } req_type;

   typedef struct packed {
      logic [INPUT_WIDTH-1:0]  input_level;
      logic [INPUT_WIDTH-1:0]  input_rise;
      logic [INPUT_WIDTH-1:0]  input_fall;
      logic [OUTPUT_WIDTH-1:0] output_pins;
      logic [OUTPUT_WIDTH-1:0] output_rise;
      logic [OUTPUT_WIDTH-1:0] output_fall;
      logic [RELAY_WIDTH-1:0]  relay_rise;
      logic [RELAY_WIDTH-1:0]  relay_fall;
   } rsp_type;

   // control from the scan pipeline to the debounce bank
   typedef struct packed {
      logic update;
      logic tick;
   } scan_ctl_type;

   // low count bits set, all bits once count reaches 64
   function automatic logic [63:0] count_mask(int count);
      logic [63:0] m;
      if (count >= 64) begin
         m = '1;
      end else begin
         m = (64'd1 << count) - 64'd1;
      end
      return m;
   endfunction

endpackage

/* design/idesc_debounce.sv */
// per-pin debounce state and accepted input levels
`timescale 1ns / 1ps

module idesc_debounce #(
   parameter int PIN_COUNT = idesc_pkg::INPUT_COUNT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  idesc_pkg::scan_ctl_type            ctl,
   input  logic [idesc_pkg::TICKS_WIDTH-1:0]  ticks,
   input  logic [PIN_COUNT-1:0]               active,
   output logic [PIN_COUNT-1:0]               level_old,
   output logic [PIN_COUNT-1:0]               level_new
);

   logic [PIN_COUNT-1:0]              sample_ff;
   logic [PIN_COUNT-1:0]              sample_in;
   logic [PIN_COUNT-1:0]              running_ff;
   logic [PIN_COUNT-1:0]              running_in;
   logic [idesc_pkg::TICKS_WIDTH-1:0] count_ff [PIN_COUNT];
   logic [idesc_pkg::TICKS_WIDTH-1:0] count_in [PIN_COUNT];
   logic [PIN_COUNT-1:0]              level_ff;
   logic [PIN_COUNT-1:0]              level_in;

   always_comb begin : pin_logic
      logic [idesc_pkg::TICKS_WIDTH-1:0] nxt;
      logic                              expire;
      sample_in  = sample_ff;
      running_in = running_ff;
      level_in   = level_ff;
      for (int i = 0; i < PIN_COUNT; i++) begin
         count_in[i] = count_ff[i];
         nxt    = count_ff[i] + 1'b1;
         // wrap to zero also ends the delay
         expire = ctl.tick && running_ff[i] && ((nxt >= ticks) || (nxt == '0));
         if (active[i] != sample_ff[i]) begin
            sample_in[i]  = active[i];
            running_in[i] = 1'b1;
            count_in[i]   = '0;
         end else if (expire) begin
            running_in[i] = 1'b0;
            count_in[i]   = '0;
            level_in[i]   = sample_ff[i];
         end else if (ctl.tick && running_ff[i]) begin
            count_in[i] = nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff  <= '0;
         running_ff <= '0;
         level_ff   <= '0;
         for (int i = 0; i < PIN_COUNT; i++) begin
            count_ff[i] <= '0;
         end
      end else if (ctl.update) begin
         sample_ff  <= sample_in;
         running_ff <= running_in;
         level_ff   <= level_in;
         for (int i = 0; i < PIN_COUNT; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   assign level_old = level_ff;
   assign level_new = level_in;

endmodule

/* design/input_debounce_and_edge_scan.sv */
// top level of the input debounce and edge scan block
`timescale 1ns / 1ps

// channel   ports                       direction  transaction
// req       req_valid req_stall req_data in         one scan: raw pins, tick, images
// rsp       rsp_valid rsp_stall rsp_data out        one scan result: levels and edges
// csr       csr_valid csr_ready csr_data in         debounce delay in ticks
//
// one scan transaction per cycle sustained while rsp_stall is low; an accepted scan
// passes through the input register, then the result register, before it leaves
// synchronous active-high reset clears all debounce state, edge history,
// valid flags, and loads the delay register with ten ticks
// a stalled result holds in the output register while the input register still
// takes one more scan; req_stall rises only when both registers are full

module input_debounce_and_edge_scan #(
   parameter int INPUT_COUNT  = idesc_pkg::INPUT_COUNT_DEFAULT,
   parameter int OUTPUT_COUNT = idesc_pkg::OUTPUT_COUNT_DEFAULT,
   parameter int RELAY_COUNT  = idesc_pkg::RELAY_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  idesc_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output idesc_pkg::rsp_type                rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [idesc_pkg::TICKS_WIDTH-1:0] csr_data
);

   localparam int IW = idesc_pkg::INPUT_WIDTH;
   localparam int OW = idesc_pkg::OUTPUT_WIDTH;
   localparam int RW = idesc_pkg::RELAY_WIDTH;

   // pins beyond the field width carry no state
   localparam int PIN_COUNT = (INPUT_COUNT < IW) ? INPUT_COUNT : IW;

   localparam logic [63:0] IMASK64 = idesc_pkg::count_mask(INPUT_COUNT);
   localparam logic [63:0] OMASK64 = idesc_pkg::count_mask(OUTPUT_COUNT);
   localparam logic [63:0] RMASK64 = idesc_pkg::count_mask(RELAY_COUNT);
   localparam logic [IW-1:0] IMASK = IMASK64[IW-1:0];
   localparam logic [OW-1:0] OMASK = OMASK64[OW-1:0];
   localparam logic [RW-1:0] RMASK = RMASK64[RW-1:0];

   // delay register
   logic [idesc_pkg::TICKS_WIDTH-1:0] ticks_ff;

   // input register
   idesc_pkg::req_type req_ff;
   logic               req_valid_ff;
   logic               req_valid_in;

   // result register
   idesc_pkg::rsp_type rsp_ff;
   idesc_pkg::rsp_type rsp_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   // edge history of the coil and relay images
   logic [OW-1:0] prev_outputs_ff;
   logic [RW-1:0] prev_relays_ff;

   logic               advance;
   logic               fire;
   logic               req_take;
   logic [OW-1:0]      oimg;
   logic [RW-1:0]      rimg;
   logic [IW-1:0]      level_old;
   logic [IW-1:0]      level_new;
   logic [PIN_COUNT-1:0] pin_level_old;
   logic [PIN_COUNT-1:0] pin_level_new;
   logic [PIN_COUNT-1:0] pin_active;
   idesc_pkg::scan_ctl_type scan_ctl;

   // handshake: result register frees when empty or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign req_valid_in = req_take || (req_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   // config write, idle only by contract
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= idesc_pkg::TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         ticks_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // raw pins are active low
   assign pin_active      = ~req_ff.raw_pins[PIN_COUNT-1:0];
   assign scan_ctl.update = fire;
   assign scan_ctl.tick   = req_ff.tick;

   idesc_debounce #(
      .PIN_COUNT (PIN_COUNT)
   ) u_debounce (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .ticks     (ticks_ff),
      .active    (pin_active),
      .level_old (pin_level_old),
      .level_new (pin_level_new)
   );

   assign level_old = IW'(pin_level_old) & IMASK;
   assign level_new = IW'(pin_level_new) & IMASK;

   assign oimg = req_ff.output_image & OMASK;
   assign rimg = req_ff.relay_image & RMASK;

   // result of the scan in the input register
   always_comb begin
      rsp_in.input_level = level_new;
      rsp_in.input_rise  = level_new & ~level_old;
      rsp_in.input_fall  = level_old & ~level_new;
      rsp_in.output_pins = ~oimg & OMASK;
      rsp_in.output_rise = oimg & ~prev_outputs_ff;
      rsp_in.output_fall = prev_outputs_ff & ~oimg;
      rsp_in.relay_rise  = rimg & ~prev_relays_ff;
      rsp_in.relay_fall  = prev_relays_ff & ~rimg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_outputs_ff <= '0;
         prev_relays_ff  <= '0;
      end else if (fire) begin
         prev_outputs_ff <= oimg;
         prev_relays_ff  <= rimg;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // back-pressure only when both stages hold a transaction
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (req_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("req_stall without both stages full");

   // an input cannot rise and fall in the same scan
   a_edge_disjoint : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.input_rise & rsp_data.input_fall) == '0))
      else $error("input rise and fall overlap");

   // edges agree with the reported level
   a_edge_level : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_data.input_rise & ~rsp_data.input_level) == '0)
                  && ((rsp_data.input_fall & rsp_data.input_level) == '0)))
      else $error("input edge disagrees with level");

   // a scan in the input register that moves forward shows up as a result
   a_fire_result : assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_valid && !req_valid_ff) || (rsp_valid && $past(req_take)))
      else $error("scan lost between stages");

endmodule
